// ===== hdl/icr_pkg.sv =====
`default_nettype none

package icr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // square root: 16 bit pairs, four per stage
  localparam int unsigned SQ_ITERS  = 16;
  localparam int unsigned SQ_STEPS  = 4;
  // long division: quotient bits per stage
  localparam int unsigned DIV_STEPS = 2;
  // largest separation magnitude is brought to [2^NORM_MSB, 2^(NORM_MSB+1))
  localparam int unsigned NORM_MSB  = 14;
  localparam int unsigned NMW       = NORM_MSB + 1;
  localparam int unsigned LENW      = 16;

  typedef struct packed {
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    logic [2:0][31:0] sep;
    logic [31:0]      ia;
    logic [31:0]      ib;
    logic [7:0]       e;
    logic             byp;
    logic             a_gt_b;
    logic             a_eq_b;
  } side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] res;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(sqrt_t st, logic [3:0] t);
    logic [31:0] bt;
    logic [32:0] trial;
    sqrt_t       r;
    bt    = 32'h4000_0000 >> {t, 1'b0};
    trial = {1'b0, st.res} + {1'b0, bt};
    if ({1'b0, st.rem} >= trial) begin
      r.rem = st.rem - trial[31:0];
      r.res = (st.res >> 1) + bt;
    end else begin
      r.rem = st.rem;
      r.res = st.res >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/impulse_collision_response.sv =====
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         valid_i / stall_o  velocities A/B, separation, inv masses, bounce
// result    out        valid_o / stall_i  new velocities A/B, position shifts A/B
//
// One contact per cycle while the result channel is not stalled.
// Reset clears only the valid bits; no clearing pass.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module impulse_collision_response #(
  parameter int unsigned FRAC_BITS = icr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] vel_a_x_i,
  input  logic signed [31:0] vel_a_y_i,
  input  logic signed [31:0] vel_a_z_i,
  input  logic signed [31:0] vel_b_x_i,
  input  logic signed [31:0] vel_b_y_i,
  input  logic signed [31:0] vel_b_z_i,
  input  logic signed [31:0] sep_x_i,
  input  logic signed [31:0] sep_y_i,
  input  logic signed [31:0] sep_z_i,
  input  logic        [31:0] inv_mass_a_i,
  input  logic        [31:0] inv_mass_b_i,
  input  logic        [15:0] bounce_pair_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] new_vel_a_x_o,
  output logic signed [31:0] new_vel_a_y_o,
  output logic signed [31:0] new_vel_a_z_o,
  output logic signed [31:0] new_vel_b_x_o,
  output logic signed [31:0] new_vel_b_y_o,
  output logic signed [31:0] new_vel_b_z_o,
  output logic signed [31:0] shift_a_x_o,
  output logic signed [31:0] shift_a_y_o,
  output logic signed [31:0] shift_a_z_o,
  output logic signed [31:0] shift_b_x_o,
  output logic signed [31:0] shift_b_y_o,
  output logic signed [31:0] shift_b_z_o
);

  import icr_pkg::*;

  localparam int unsigned QW      = FRAC_BITS + 1;
  localparam int unsigned NW      = FRAC_BITS + 2;
  localparam int unsigned SQ_STG  = SQ_ITERS / SQ_STEPS;
  localparam int unsigned DIV_STG = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned NV      = 10 + SQ_STG + DIV_STG;
  localparam int unsigned DNW     = FRAC_BITS + NMW + 1;
  localparam int unsigned DVW     = 33 + NW;
  localparam int unsigned DOTW    = DVW + 2;
  localparam int unsigned VNW     = DOTW - FRAC_BITS;
  localparam int unsigned KPW     = 10 + VNW;
  localparam int unsigned KW      = KPW - 7;
  localparam int unsigned GPW     = KW + QW + 1;
  localparam int unsigned GW      = GPW - FRAC_BITS;
  localparam int unsigned IPW     = GW + NW;
  localparam int unsigned IW      = IPW - FRAC_BITS;
  localparam int unsigned SPW     = 32 + QW + 1;
  localparam int unsigned SQL     = SQ_STG - 1;
  localparam int unsigned DVL     = DIV_STG - 1;

  localparam logic [QW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [QW-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  logic          en;
  logic [NV-1:0] v_q;

  assign valid_o = v_q[NV-1];
  assign stall_o = v_q[NV-1] & stall_i;
  assign en      = ~stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NV-2:0], valid_i};
    end
  end

  // ---------------- stage A: magnitudes, max, special cases
  logic [2:0][31:0] in_sep, mag_a_d, mag_a_q;
  logic [31:0]      m_a_d, m_a_q;
  side_t            side_a_d, side_a_q;

  assign in_sep = {sep_z_i, sep_y_i, sep_x_i};

  always_comb begin
    side_a_d.va     = {vel_a_z_i, vel_a_y_i, vel_a_x_i};
    side_a_d.vb     = {vel_b_z_i, vel_b_y_i, vel_b_x_i};
    side_a_d.sep    = in_sep;
    side_a_d.ia     = inv_mass_a_i;
    side_a_d.ib     = inv_mass_b_i;
    side_a_d.e      = (bounce_pair_i[7:0] < bounce_pair_i[15:8]) ? bounce_pair_i[7:0]
                                                                 : bounce_pair_i[15:8];
    side_a_d.a_gt_b = inv_mass_a_i > inv_mass_b_i;
    side_a_d.a_eq_b = inv_mass_a_i == inv_mass_b_i;
    m_a_d = '0;
    for (int i = 0; i < 3; i++) begin
      mag_a_d[i] = in_sep[i][31] ? (~in_sep[i] + 32'd1) : in_sep[i];
      if (mag_a_d[i] > m_a_d) m_a_d = mag_a_d[i];
    end
    side_a_d.byp = (m_a_d == '0) || (inv_mass_a_i == '0 && inv_mass_b_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q <= side_a_d;
      mag_a_q  <= mag_a_d;
      m_a_q    <= m_a_d;
    end
  end

  // ---------------- stage B: leading one of the max
  logic [4:0]       pos_b_d, pos_b_q;
  logic [2:0][31:0] mag_b_q;
  side_t            side_b_q;

  always_comb begin
    pos_b_d = '0;
    for (int b = 0; b < 32; b++) begin
      if (m_a_q[b]) pos_b_d = 5'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_b_q  <= pos_b_d;
      mag_b_q  <= mag_a_q;
      side_b_q <= side_a_q;
    end
  end

  // ---------------- stage C: normalizing shift
  logic [2:0][NMW-1:0] nm_c_d, nm_c_q;
  logic [31:0]         shv;
  side_t               side_c_q;

  always_comb begin
    shv = '0;
    for (int i = 0; i < 3; i++) begin
      if (pos_b_q > 5'(NORM_MSB)) begin
        shv = mag_b_q[i] >> (pos_b_q - 5'(NORM_MSB));
      end else begin
        shv = mag_b_q[i] << (5'(NORM_MSB) - pos_b_q);
      end
      nm_c_d[i] = shv[NMW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm_c_q   <= nm_c_d;
      side_c_q <= side_b_q;
    end
  end

  // ---------------- stage D: sum of squares
  logic [31:0]         sq_d_d, sq_d_q, ext0, ext1, ext2;
  logic [2:0][NMW-1:0] nm_d_q;
  side_t               side_d_q;

  assign ext0   = 32'(nm_c_q[0]);
  assign ext1   = 32'(nm_c_q[1]);
  assign ext2   = 32'(nm_c_q[2]);
  assign sq_d_d = ext0 * ext0 + ext1 * ext1 + ext2 * ext2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_d_q   <= sq_d_d;
      nm_d_q   <= nm_c_q;
      side_d_q <= side_c_q;
    end
  end

  // ---------------- square root stages
  sqrt_t               sq_q   [SQ_STG];
  side_t               side_s_q [SQ_STG];
  logic [2:0][NMW-1:0] nm_s_q [SQ_STG];

  for (genvar g = 0; g < SQ_STG; g++) begin : g_sqrt
    sqrt_t               st_in, st_out;
    side_t               sd_in;
    logic [2:0][NMW-1:0] nm_in;

    if (g == 0) begin : g_first
      assign st_in = '{rem: sq_d_q, res: 32'd0};
      assign sd_in = side_d_q;
      assign nm_in = nm_d_q;
    end else begin : g_next
      assign st_in = sq_q[g-1];
      assign sd_in = side_s_q[g-1];
      assign nm_in = nm_s_q[g-1];
    end

    always_comb begin
      st_out = st_in;
      for (int j = 0; j < SQ_STEPS; j++) begin
        st_out = sqrt_step(st_out, 4'(g * SQ_STEPS + j));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[g]     <= st_out;
        side_s_q[g] <= sd_in;
        nm_s_q[g]   <= nm_in;
      end
    end
  end

  // ---------------- dividers: normal, impulse weight, position split
  logic [LENW-1:0]        len;
  side_t                  sd_s;
  logic [2:0][DNW-1:0]    dnum;
  logic [2:0][LENW-1:0]   hi_n;
  logic [2:0][QW-1:0]     lo_n, qn;
  logic [32:0]            wsum;
  logic [31:0]            pnum, pden;
  logic [QW-1:0]          qw, qp;
  side_t                  side_v_q [DIV_STG];

  assign len  = sq_q[SQL].res[LENW-1:0];
  assign sd_s = side_s_q[SQL];
  assign wsum = {1'b0, sd_s.ia} + {1'b0, sd_s.ib};
  assign pnum = sd_s.a_gt_b ? sd_s.ib : sd_s.ia;
  assign pden = sd_s.a_gt_b ? sd_s.ia : sd_s.ib;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dnum[i] = DNW'({nm_s_q[SQL][i], {FRAC_BITS{1'b0}}}) + DNW'(len[LENW-1:1]);
      hi_n[i] = {1'b0, dnum[i][DNW-1:FRAC_BITS+1]};
      lo_n[i] = dnum[i][FRAC_BITS:0];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    icr_div #(.DW(LENW), .QW(QW), .STEPS(DIV_STEPS)) u_div_n (
      .clk_i (clk_i),
      .en_i  (en),
      .hi_i  (hi_n[i]),
      .lo_i  (lo_n[i]),
      .div_i (len),
      .q_o   (qn[i])
    );
  end

  icr_div #(.DW(33), .QW(QW), .STEPS(DIV_STEPS)) u_div_w (
    .clk_i (clk_i),
    .en_i  (en),
    .hi_i  ({2'b00, sd_s.ia[31:1]}),
    .lo_i  ({sd_s.ia[0], {FRAC_BITS{1'b0}}}),
    .div_i (wsum),
    .q_o   (qw)
  );

  icr_div #(.DW(32), .QW(QW), .STEPS(DIV_STEPS)) u_div_p (
    .clk_i (clk_i),
    .en_i  (en),
    .hi_i  ({1'b0, pnum[31:1]}),
    .lo_i  ({pnum[0], {FRAC_BITS{1'b0}}}),
    .div_i (pden),
    .q_o   (qp)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_v_q[0] <= sd_s;
      for (int k = 1; k < DIV_STG; k++) side_v_q[k] <= side_v_q[k-1];
    end
  end

  // ---------------- stage M1: signed normal, products
  side_t                sv;
  logic signed [NW-1:0] n_c [3];
  logic [QW-1:0]        wb_c, pa_c, pb_c;
  logic signed [32:0]   dv;
  logic signed [DVW-1:0] dvn_m1_d [3], dvn_m1_q [3];
  logic signed [SPW-1:0] sa_m1_d [3], sb_m1_d [3], sa_m1_q [3], sb_m1_q [3];
  logic signed [NW-1:0] n_m1_q [3];
  logic [QW-1:0]        wa_m1_q, wb_m1_q;
  side_t                side_m1_q;

  assign sv   = side_v_q[DVL];
  assign wb_c = ONE - qw;

  always_comb begin
    if (sv.a_eq_b) begin
      pa_c = HALF;
      pb_c = HALF;
    end else if (sv.a_gt_b) begin
      pb_c = qp;
      pa_c = ONE - qp;
    end else begin
      pa_c = qp;
      pb_c = ONE - qp;
    end
    dv = '0;
    for (int i = 0; i < 3; i++) begin
      n_c[i] = sv.sep[i][31] ? -signed'({1'b0, qn[i]}) : signed'({1'b0, qn[i]});
      dv = 33'(signed'(sv.vb[i])) - 33'(signed'(sv.va[i]));
      dvn_m1_d[i] = DVW'(dv) * DVW'(n_c[i]);
      sa_m1_d[i]  = SPW'(signed'(sv.sep[i])) * SPW'(signed'({1'b0, pa_c}));
      sb_m1_d[i]  = SPW'(signed'(sv.sep[i])) * SPW'(signed'({1'b0, pb_c}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvn_m1_q  <= dvn_m1_d;
      sa_m1_q   <= sa_m1_d;
      sb_m1_q   <= sb_m1_d;
      n_m1_q    <= n_c;
      wa_m1_q   <= qw;
      wb_m1_q   <= wb_c;
      side_m1_q <= sv;
    end
  end

  // ---------------- stage M2: dot product, position shifts
  logic [DOTW-1:0]       dot;
  logic signed [VNW-1:0] vn_m2_q;
  logic [31:0]           sha_m2_d [3], shb_m2_d [3], sha_m2_q [3], shb_m2_q [3];
  logic signed [NW-1:0]  n_m2_q [3];
  logic [QW-1:0]         wa_m2_q, wb_m2_q;
  side_t                 side_m2_q;

  assign dot = DOTW'(dvn_m1_q[0]) + DOTW'(dvn_m1_q[1]) + DOTW'(dvn_m1_q[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sha_m2_d[i] = sat32(-(64'(signed'(sa_m1_q[i][SPW-1:FRAC_BITS]))));
      shb_m2_d[i] = sat32(64'(signed'(sb_m1_q[i][SPW-1:FRAC_BITS])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vn_m2_q   <= signed'(dot[DOTW-1:FRAC_BITS]);
      sha_m2_q  <= sha_m2_d;
      shb_m2_q  <= shb_m2_d;
      n_m2_q    <= n_m1_q;
      wa_m2_q   <= wa_m1_q;
      wb_m2_q   <= wb_m1_q;
      side_m2_q <= side_m1_q;
    end
  end

  // ---------------- stage M3: restitution scale
  logic [8:0]            eplus;
  logic [KPW-1:0]        kp;
  logic signed [KW-1:0]  k_m3_q;
  logic [31:0]           sha_m3_q [3], shb_m3_q [3];
  logic signed [NW-1:0]  n_m3_q [3];
  logic [QW-1:0]         wa_m3_q, wb_m3_q;
  side_t                 side_m3_q;

  assign eplus = 9'd128 + {1'b0, side_m2_q.e};
  assign kp    = KPW'(signed'({1'b0, eplus})) * KPW'(vn_m2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_m3_q    <= signed'(kp[KPW-1:7]);
      sha_m3_q  <= sha_m2_q;
      shb_m3_q  <= shb_m2_q;
      n_m3_q    <= n_m2_q;
      wa_m3_q   <= wa_m2_q;
      wb_m3_q   <= wb_m2_q;
      side_m3_q <= side_m2_q;
    end
  end

  // ---------------- stage M4: impulse shares
  logic [GPW-1:0]        gpa, gpb;
  logic signed [GW-1:0]  ga_m4_q, gb_m4_q;
  logic [31:0]           sha_m4_q [3], shb_m4_q [3];
  logic signed [NW-1:0]  n_m4_q [3];
  side_t                 side_m4_q;

  assign gpa = GPW'(k_m3_q) * GPW'(signed'({1'b0, wa_m3_q}));
  assign gpb = GPW'(k_m3_q) * GPW'(signed'({1'b0, wb_m3_q}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      ga_m4_q   <= signed'(gpa[GPW-1:FRAC_BITS]);
      gb_m4_q   <= signed'(gpb[GPW-1:FRAC_BITS]);
      sha_m4_q  <= sha_m3_q;
      shb_m4_q  <= shb_m3_q;
      n_m4_q    <= n_m3_q;
      side_m4_q <= side_m3_q;
    end
  end

  // ---------------- stage M5: impulse along the normal
  logic [IPW-1:0]        ipa [3], ipb [3];
  logic signed [IW-1:0]  da_m5_q [3], db_m5_q [3];
  logic [31:0]           sha_m5_q [3], shb_m5_q [3];
  side_t                 side_m5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ipa[i] = IPW'(ga_m4_q) * IPW'(n_m4_q[i]);
      ipb[i] = IPW'(gb_m4_q) * IPW'(n_m4_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        da_m5_q[i] <= signed'(ipa[i][IPW-1:FRAC_BITS]);
        db_m5_q[i] <= signed'(ipb[i][IPW-1:FRAC_BITS]);
      end
      sha_m5_q  <= sha_m4_q;
      shb_m5_q  <= shb_m4_q;
      side_m5_q <= side_m4_q;
    end
  end

  // ---------------- output register
  logic [2:0][31:0] nva_d, nvb_d, sa_d, sb_d, nva_q, nvb_q, sa_q, sb_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_m5_q.byp) begin
        nva_d[i] = side_m5_q.va[i];
        nvb_d[i] = side_m5_q.vb[i];
        sa_d[i]  = '0;
        sb_d[i]  = '0;
      end else begin
        nva_d[i] = sat32(64'(signed'(side_m5_q.va[i])) + 64'(da_m5_q[i]));
        nvb_d[i] = sat32(64'(signed'(side_m5_q.vb[i])) - 64'(db_m5_q[i]));
        sa_d[i]  = sha_m5_q[i];
        sb_d[i]  = shb_m5_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nva_q <= nva_d;
      nvb_q <= nvb_d;
      sa_q  <= sa_d;
      sb_q  <= sb_d;
    end
  end

  assign new_vel_a_x_o = signed'(nva_q[0]);
  assign new_vel_a_y_o = signed'(nva_q[1]);
  assign new_vel_a_z_o = signed'(nva_q[2]);
  assign new_vel_b_x_o = signed'(nvb_q[0]);
  assign new_vel_b_y_o = signed'(nvb_q[1]);
  assign new_vel_b_z_o = signed'(nvb_q[2]);
  assign shift_a_x_o   = signed'(sa_q[0]);
  assign shift_a_y_o   = signed'(sa_q[1]);
  assign shift_a_z_o   = signed'(sa_q[2]);
  assign shift_b_x_o   = signed'(sb_q[0]);
  assign shift_b_y_o   = signed'(sb_q[1]);
  assign shift_b_z_o   = signed'(sb_q[2]);

  // ---------------- checks
  a_norm_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[2] && !side_c_q.byp) |->
      (nm_c_q[0][NORM_MSB] || nm_c_q[1][NORM_MSB] || nm_c_q[2][NORM_MSB]))
    else $error("normalized separation lost its leading bit");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3 + SQ_STG] && !sd_s.byp) |-> (len[LENW-1:LENW-2] != 2'b00))
    else $error("vector length below normalized range");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3 + SQ_STG + DIV_STG] && !sv.byp) |->
      (qn[0] <= ONE && qn[1] <= ONE && qn[2] <= ONE && qw <= ONE && qp <= ONE))
    else $error("normal or share above one");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(v_q))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== hdl/icr_div.sv =====
`default_nettype none

// Pipelined restoring divider. hi_i must be below div_i; lo_i is shifted in
// MSB first, one quotient bit per step.
module icr_div #(
  parameter int unsigned DW    = 16,
  parameter int unsigned QW    = 17,
  parameter int unsigned STEPS = 2
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] hi_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] div_i,
  output logic [QW-1:0] q_o
);

  localparam int unsigned NSTG = (QW + STEPS - 1) / STEPS;

  logic [DW-1:0] rem_q [NSTG];
  logic [DW-1:0] dv_q  [NSTG];
  logic [QW-1:0] lo_q  [NSTG];
  logic [QW-1:0] q_q   [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic [DW-1:0] rem_in, dv_in, rem_nx;
    logic [QW-1:0] lo_in, q_in, lo_nx, q_nx;
    logic [DW:0]   trial;

    if (g == 0) begin : g_first
      assign rem_in = hi_i;
      assign dv_in  = div_i;
      assign lo_in  = lo_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign dv_in  = dv_q[g-1];
      assign lo_in  = lo_q[g-1];
      assign q_in   = q_q[g-1];
    end

    always_comb begin
      rem_nx = rem_in;
      lo_nx  = lo_in;
      q_nx   = q_in;
      trial  = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (g * STEPS + j < QW) begin
          trial = {rem_nx, lo_nx[QW-1]};
          lo_nx = lo_nx << 1;
          if (trial >= {1'b0, dv_in}) begin
            trial = trial - {1'b0, dv_in};
            q_nx  = {q_nx[QW-2:0], 1'b1};
          end else begin
            q_nx  = {q_nx[QW-2:0], 1'b0};
          end
          rem_nx = trial[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_nx;
        dv_q[g]  <= dv_in;
        lo_q[g]  <= lo_nx;
        q_q[g]   <= q_nx;
      end
    end
  end

  assign q_o = q_q[NSTG-1];

endmodule

`default_nettype wire

// ===== sim/tb_impulse_collision_response.sv =====
`default_nettype none

module tb_impulse_collision_response;
  import icr_pkg::*;

  localparam int unsigned FB        = FRAC_BITS_DEF;
  localparam int          N_RANDOM  = 440;
  localparam int          LATENCY   = 10 + 4 + (FB + 2) / 2;
  localparam int          CYC_LIMIT = 400000;
  localparam int          N_FIELDS  = 12;

  typedef struct packed {
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    logic [2:0][31:0] sep;
    logic [31:0]      ia;
    logic [31:0]      ib;
    logic [15:0]      bounce;
  } contact_t;

  // order: new vel A xyz, new vel B xyz, shift A xyz, shift B xyz
  typedef logic [N_FIELDS-1:0][31:0] response_t;

  typedef struct packed {
    contact_t  c;
    logic      typed;
    response_t r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o;
  contact_t drv = '0;
  logic [N_FIELDS-1:0][31:0] got;

  response_t expected_q[$];
  int errors = 0;
  int responses_seen = 0;
  int cycles = 0;
  string field_names[N_FIELDS] = '{"new_vel_a_x", "new_vel_a_y", "new_vel_a_z",
    "new_vel_b_x", "new_vel_b_y", "new_vel_b_z", "shift_a_x", "shift_a_y", "shift_a_z",
    "shift_b_x", "shift_b_y", "shift_b_z"};

  impulse_collision_response dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .vel_a_x_i(drv.va[0]), .vel_a_y_i(drv.va[1]), .vel_a_z_i(drv.va[2]),
    .vel_b_x_i(drv.vb[0]), .vel_b_y_i(drv.vb[1]), .vel_b_z_i(drv.vb[2]),
    .sep_x_i(drv.sep[0]), .sep_y_i(drv.sep[1]), .sep_z_i(drv.sep[2]),
    .inv_mass_a_i(drv.ia), .inv_mass_b_i(drv.ib), .bounce_pair_i(drv.bounce),
    .valid_o(valid_o), .stall_i(stall_i),
    .new_vel_a_x_o(got[0]), .new_vel_a_y_o(got[1]), .new_vel_a_z_o(got[2]),
    .new_vel_b_x_o(got[3]), .new_vel_b_y_o(got[4]), .new_vel_b_z_o(got[5]),
    .shift_a_x_o(got[6]), .shift_a_y_o(got[7]), .shift_a_z_o(got[8]),
    .shift_b_x_o(got[9]), .shift_b_y_o(got[10]), .shift_b_z_o(got[11])
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] res, bit_w;
    res = 0;
    bit_w = 32'h4000_0000;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic response_t resolve_contact(contact_t c);
    logic signed [63:0] va[3], vb[3], s[3], n[3];
    logic signed [63:0] dot, vn, k, ga, gb, wa, wb, pa, pb, one;
    logic [63:0] q, ia, ib, isum;
    logic [31:0] mag[3], m, sq, len;
    logic [7:0] e;
    response_t r;
    one = 64'sd1 <<< FB;
    ia = {32'd0, c.ia};
    ib = {32'd0, c.ib};
    isum = ia + ib;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      va[i] = {{32{c.va[i][31]}}, c.va[i]};
      vb[i] = {{32{c.vb[i][31]}}, c.vb[i]};
      s[i] = {{32{c.sep[i][31]}}, c.sep[i]};
      mag[i] = s[i] < 0 ? 32'(-s[i]) : 32'(s[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0 || isum == 0) begin
      for (int i = 0; i < 3; i++) begin
        r[i] = c.va[i];
        r[3+i] = c.vb[i];
        r[6+i] = '0;
        r[9+i] = '0;
      end
      return r;
    end
    while (m >= 32'h8000) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < 32'h4000) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = (({32'd0, mag[i]} << FB) + {33'd0, len[31:1]}) / {32'd0, len};
      n[i] = s[i] < 0 ? -$signed(q) : $signed(q);
    end
    e = c.bounce[7:0] < c.bounce[15:8] ? c.bounce[7:0] : c.bounce[15:8];
    dot = 0;
    for (int i = 0; i < 3; i++) dot = dot + (vb[i] - va[i]) * n[i];
    vn = dot >>> FB;
    k = ((64'sd128 + $signed({56'd0, e})) * vn) >>> 7;
    wa = $signed((ia << FB) / isum);
    wb = one - wa;
    ga = (k * wa) >>> FB;
    gb = (k * wb) >>> FB;
    if (ia > ib) begin
      pb = $signed((ib << FB) / ia);
      pa = one - pb;
    end else if (ia < ib) begin
      pa = $signed((ia << FB) / ib);
      pb = one - pa;
    end else begin
      pa = one >>> 1;
      pb = one >>> 1;
    end
    for (int i = 0; i < 3; i++) begin
      r[i] = clamp32(va[i] + ((ga * n[i]) >>> FB));
      r[3+i] = clamp32(vb[i] - ((gb * n[i]) >>> FB));
      r[6+i] = clamp32(-((s[i] * pa) >>> FB));
      r[9+i] = clamp32((s[i] * pb) >>> FB);
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] small_signed(int unsigned bits);
    return $urandom_range(0, (1 << (bits + 1)) - 1) - (1 << bits);
  endfunction

  function automatic contact_t random_contact();
    contact_t c;
    int mode;
    mode = $urandom_range(0, 11);
    c.bounce = 16'($urandom());
    for (int i = 0; i < 3; i++) begin
      c.va[i] = small_signed(20);
      c.vb[i] = small_signed(20);
      c.sep[i] = small_signed($urandom_range(2, 24));
    end
    c.ia = $urandom_range(0, 9) == 0 ? 32'd0 : $urandom_range(1, 1 << 20);
    c.ib = $urandom_range(0, 9) == 0 ? 32'd0 : $urandom_range(1, 1 << 20);
    case (mode)
      7: c = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())};
      8: c.sep = '0;
      9: c.ib = c.ia;
      10: begin
        for (int i = 0; i < 3; i++) begin
          c.va[i] = pick_edge();
          c.vb[i] = pick_edge();
          c.sep[i] = pick_edge();
        end
        c.ia = pick_edge();
        c.ib = pick_edge();
      end
      11: begin
        c.ia = '0;
        c.ib = '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic response_t passthrough(contact_t c);
    response_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      r[i] = c.va[i];
      r[3+i] = c.vb[i];
    end
    return r;
  endfunction

  function automatic contact_t mk(logic [31:0] v, logic [31:0] s0, logic [31:0] s1,
                                  logic [31:0] a, logic [31:0] b, logic [15:0] bp);
    contact_t c;
    c.va = {v, -v, v ^ 32'h1234_5678};
    c.vb = {-v, v, 32'h0001_0000};
    c.sep = {s0, s1, s0 ^ s1};
    c.ia = a;
    c.ib = b;
    c.bounce = bp;
    return c;
  endfunction

  // transfer bookkeeping at the rising edge
  always @(posedge clk_i) begin
    response_t exp_r;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        responses_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected", $time);
        end else begin
          exp_r = expected_q.pop_front();
          for (int i = 0; i < N_FIELDS; i++) begin
            if (got[i] !== exp_r[i]) begin
              errors++;
              $display("%0t: %s expected %h actual %h", $time, field_names[i], exp_r[i],
                       got[i]);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("[impulse_collision_response] ERROR");
      $finish;
    end
  end

  // receiver: own stall pattern plus one long hold-off
  initial begin
    int phase;
    bit held;
    phase = 0;
    held = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (!held && responses_seen >= 120) begin
        held = 1;
        stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        stall_i = 1'b0;
      end else if ((phase / 200) % 3 == 2) begin
        stall_i = 1'b0;
      end else begin
        stall_i = (phase % 7 == 3) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic send_contact(contact_t c, response_t exp_r);
    drv = c;
    valid_i = 1'b1;
    do @(posedge clk_i); while (stall_o);
    expected_q.insert(expected_q.size(), exp_r);
    @(negedge clk_i);
  endtask

  task automatic sender_gap(ref int burst);
    int gap;
    if (burst > 0) begin
      burst--;
      return;
    end
    burst = $urandom_range(0, 12);
    gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    row_t rows[14];
    contact_t c;
    response_t r;
    int burst;
    int settle;
    burst = 0;
    rows[0]  = '{mk(32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16'h4040),
                 1'b1, '0};
    rows[1]  = '{mk(32'h8000_0000, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 16'hffff),
                 1'b1, '0};
    rows[2]  = '{mk(32'h7fff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 16'h0),
                 1'b1, '0};
    rows[3]  = '{mk(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000,
                    16'h8080), 1'b0, '0};
    rows[4]  = '{mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                    32'hffff_ffff, 16'hffff), 1'b0, '0};
    rows[5]  = '{mk(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0, 16'hff00),
                 1'b0, '0};
    rows[6]  = '{mk(32'h0001_0000, 32'h1, 32'h0, 32'h0, 32'h0000_8000, 16'h00ff),
                 1'b0, '0};
    rows[7]  = '{mk(32'hfffe_0000, 32'h0000_4000, 32'hffff_c000, 32'h0002_0000,
                    32'h0000_8000, 16'h2050), 1'b0, '0};
    rows[8]  = '{mk(32'h0000_1000, 32'h0010_0000, 32'h0000_0003, 32'h0000_8000,
                    32'h0002_0000, 16'h5020), 1'b0, '0};
    rows[9]  = '{mk(32'h1234_5678, 32'hffff_ffff, 32'h0000_0001, 32'h1, 32'hffff_ffff,
                    16'h7f01), 1'b0, '0};
    rows[10] = '{mk(32'h4000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h1,
                    16'h00ff), 1'b0, '0};
    rows[11] = '{mk(32'hc000_0000, 32'h0000_0001, 32'h0, 32'h0001_0000, 32'h0001_0000,
                    16'h0000), 1'b0, '0};
    rows[12] = '{mk(32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                    32'h0000_0001, 16'h8000), 1'b0, '0};
    rows[13] = '{mk(32'h0000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0), 1'b1, '0};
    // typed rows are all pass-through cases: zero separation or both masses zero
    for (int i = 0; i < 14; i++) begin
      if (rows[i].typed) rows[i].r = passthrough(rows[i].c);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      r = rows[i].typed ? rows[i].r : resolve_contact(rows[i].c);
      send_contact(rows[i].c, r);
      sender_gap(burst);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) begin
        valid_i = 1'b0;
        while (expected_q.size() != 0) @(negedge clk_i);
      end
      c = random_contact();
      send_contact(c, resolve_contact(c));
      sender_gap(burst);
    end
    valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    settle = LATENCY + 10;
    repeat (settle) @(negedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[impulse_collision_response] OK");
    end else begin
      $display("[impulse_collision_response] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/icr_pkg.sv
hdl/icr_div.sv
hdl/impulse_collision_response.sv
sim/tb_impulse_collision_response.sv
